/* rtl/core/ecs_pkg.sv */
package ecs_pkg;

    // Character codes the filter looks for.
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_B      = 8'h42;
    localparam logic [7:0] CH_F      = 8'h46;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_X      = 8'h58;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_LOW_X  = 8'h78;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;

    // Number of words in the rewrite of a color code.
    localparam logic [2:0] REWRITE_LEN = 3'd7;

    // Recognizer state, one-hot.
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_TILDE  = 4'b0010,
        ST_LETTER = 4'b0100,
        ST_DIGIT  = 4'b1000
    } ecs_state_t;

    // One command from the front end to the back end. The back end emits
    // the first held_cnt bytes of tilde, letter, digit, then ch if tail is
    // set; or the seven-word rewrite; or a single empty end marker.
    typedef struct packed {
        logic       last;
        logic       empty;
        logic       rewrite;
        logic       tail;
        logic [1:0] held_cnt;
        logic [7:0] ch;
        logic [7:0] letter;
        logic [7:0] digit;
    } ecs_cmd_t;

    // True for ASCII hex digits in either case.
    function automatic logic is_hex(input logic [7:0] c);
        is_hex = ((c >= 8'h30) && (c <= 8'h39)) ||
                 ((c >= 8'h61) && (c <= 8'h66)) ||
                 ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    // Word idx of the rewrite "$0x(hh)".
    function automatic logic [7:0] rewrite_byte(input logic [2:0] idx,
                                                input logic [7:0] d1,
                                                input logic [7:0] d2);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = CH_DOLLAR;
            3'd1:    b = CH_ZERO;
            3'd2:    b = CH_LOW_X;
            3'd3:    b = CH_LPAREN;
            3'd4:    b = d1;
            3'd5:    b = d2;
            default: b = CH_RPAREN;
        endcase
        rewrite_byte = b;
    endfunction

endpackage

/* rtl/core/escape_code_stripper_top.sv */
// Tilde escape code filter. Each input word is one byte of text with a mark on
// the final byte of a string; each output word is one byte (char_valid high) or,
// when the final byte ends a dropped code, an empty end marker (char_valid low),
// with last_out on the final word of the string. A front end recognizes codes and
// issues one command per byte that produces output; a two-entry command queue
// decouples it from a back end that emits one output word per cycle while res_ready
// is high. A byte that yields at most one word sustains one byte per cycle while
// res_ready stays high; a broken partial code puts up to four words through the back
// end and a ~C rewrite seven, and input stalls only once the queue is full. An input
// byte is registered in the queue and then in the back end's output register.
module escape_code_stripper_top
    import ecs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_ready,
    input  logic [7:0] char_in,
    input  logic       last_in,
    output logic       res_valid,
    input  logic       res_ready,
    output logic [7:0] char_out,
    output logic       char_valid,
    output logic       last_out
);

    logic     accept;
    logic     push;
    ecs_cmd_t push_cmd;
    logic     full;
    logic     pop;
    logic     cmd_valid;
    ecs_cmd_t cmd;

    assign byte_ready = !full;
    assign accept     = byte_valid && byte_ready;

    ecs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .char_in  (char_in),
        .last_in  (last_in),
        .push     (push),
        .push_cmd (push_cmd)
    );

    ecs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (full),
        .pop       (pop),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    ecs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .pop        (pop),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .char_out   (char_out),
        .char_valid (char_valid),
        .last_out   (last_out)
    );

endmodule

/* rtl/core/ecs_front.sv */
module ecs_front
    import ecs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] char_in,
    input  logic       last_in,
    output logic       push,
    output ecs_cmd_t   push_cmd
);

    ecs_state_t state_reg, state_next;
    logic [7:0] letter_reg, letter_next;
    logic [7:0] digit_reg, digit_next;

    logic       hex_c;
    logic       letter_c;
    logic       cont;
    logic       drop;
    logic       rew;
    logic       fail;
    logic [1:0] held_n;
    logic       has_out;

    assign hex_c    = is_hex(char_in);
    assign letter_c = (char_in == CH_B) || (char_in == CH_F) ||
                      (char_in == CH_C) || (char_in == CH_X);

    // Classify the word against the partial code held so far.
    always_comb
    begin
        cont   = 1'b0;
        drop   = 1'b0;
        rew    = 1'b0;
        fail   = 1'b0;
        held_n = 2'd0;
        unique case (state_reg)
            ST_IDLE:
            begin
                fail = 1'b1;
            end
            ST_TILDE:
            begin
                held_n = 2'd1;
                cont   = letter_c;
                fail   = !letter_c;
            end
            ST_LETTER:
            begin
                held_n = 2'd2;
                if (!hex_c)
                    fail = 1'b1;
                else if ((letter_reg == CH_B) || (letter_reg == CH_F))
                    drop = 1'b1;
                else
                    cont = 1'b1;
            end
            ST_DIGIT:
            begin
                held_n = 2'd3;
                if (!hex_c)
                    fail = 1'b1;
                else if (letter_reg == CH_C)
                    rew = 1'b1;
                else
                    drop = 1'b1;
            end
            default:
            begin
                fail = 1'b1;
            end
        endcase
    end

    // Build the command and the next state.
    always_comb
    begin
        state_next        = state_reg;
        letter_next       = letter_reg;
        digit_next        = digit_reg;
        push_cmd.last     = last_in;
        push_cmd.empty    = 1'b0;
        push_cmd.rewrite  = 1'b0;
        push_cmd.tail     = 1'b0;
        push_cmd.held_cnt = 2'd0;
        push_cmd.ch       = char_in;
        push_cmd.letter   = letter_reg;
        push_cmd.digit    = digit_reg;
        if (fail)
        begin
            // Held bytes go out unchanged; the word is looked at afresh.
            push_cmd.held_cnt = held_n;
            if ((char_in == CH_TILDE) && !last_in)
                state_next = ST_TILDE;
            else
            begin
                push_cmd.tail = 1'b1;
                state_next    = ST_IDLE;
            end
        end
        else if (cont)
        begin
            if (last_in)
            begin
                // End of string flushes the partial code including this word.
                push_cmd.held_cnt = held_n;
                push_cmd.tail     = 1'b1;
                state_next        = ST_IDLE;
            end
            else if (state_reg == ST_TILDE)
            begin
                letter_next = char_in;
                state_next  = ST_LETTER;
            end
            else
            begin
                digit_next = char_in;
                state_next = ST_DIGIT;
            end
        end
        else if (rew)
        begin
            push_cmd.rewrite = 1'b1;
            state_next       = ST_IDLE;
        end
        else if (drop)
        begin
            state_next = ST_IDLE;
        end
        has_out = (push_cmd.held_cnt != 2'd0) || push_cmd.tail || push_cmd.rewrite;
        push_cmd.empty = last_in && !has_out;
        push = accept && (has_out || last_in);
    end

    // Recognizer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else if (accept)
            state_reg <= state_next;
    end

    // Held letter and digit.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            letter_reg <= letter_next;
            digit_reg  <= digit_next;
        end
    end

endmodule

/* rtl/core/ecs_queue.sv */
module ecs_queue
    import ecs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  ecs_cmd_t push_cmd,
    output logic     full,
    input  logic     pop,
    output logic     cmd_valid,
    output ecs_cmd_t cmd
);

    ecs_cmd_t   mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = mem[rd_ptr_reg];

    // Occupancy tracking.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    // Pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_cmd;
    end

endmodule

/* rtl/core/ecs_back.sv */
module ecs_back
    import ecs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    input  ecs_cmd_t   cmd,
    output logic       pop,
    output logic       res_valid,
    input  logic       res_ready,
    output logic [7:0] char_out,
    output logic       char_valid,
    output logic       last_out
);

    logic [2:0] idx_reg, idx_next;
    logic       valid_reg;
    logic [7:0] char_reg, char_next;
    logic       cvalid_reg, cvalid_next;
    logic       last_reg;
    logic [2:0] len;
    logic       final_word;
    logic       load;

    assign res_valid  = valid_reg;
    assign char_out   = char_reg;
    assign char_valid = cvalid_reg;
    assign last_out   = last_reg;

    assign load = cmd_valid && (!valid_reg || res_ready);
    assign pop  = load && final_word;

    // Pick the next word of the current command.
    always_comb
    begin
        cvalid_next = 1'b1;
        if (cmd.rewrite)
        begin
            len       = REWRITE_LEN;
            char_next = rewrite_byte(idx_reg, cmd.digit, cmd.ch);
        end
        else if (cmd.empty)
        begin
            len         = 3'd1;
            char_next   = 8'h00;
            cvalid_next = 1'b0;
        end
        else
        begin
            len = {1'b0, cmd.held_cnt} + {2'b00, cmd.tail};
            if (idx_reg == {1'b0, cmd.held_cnt})
                char_next = cmd.ch;
            else if (idx_reg == 3'd0)
                char_next = CH_TILDE;
            else if (idx_reg == 3'd1)
                char_next = cmd.letter;
            else
                char_next = cmd.digit;
        end
        final_word = (idx_reg == (len - 3'd1));
        idx_next   = final_word ? 3'd0 : (idx_reg + 3'd1);
    end

    // Word counter and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                idx_reg <= idx_next;
            if (load)
                valid_reg <= 1'b1;
            else if (res_ready)
                valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg   <= char_next;
            cvalid_reg <= cvalid_next;
            last_reg   <= cmd.last && final_word;
        end
    end

endmodule

/* dv/escape_code_stripper_checker.sv */
`timescale 1ns / 100ps

module escape_code_stripper_checker
    import ecs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    input  logic       byte_ready,
    input  logic [7:0] char_in,
    input  logic       last_in,
    input  logic       res_valid,
    input  logic       res_ready,
    input  logic [7:0] char_out,
    input  logic       char_valid,
    input  logic       last_out,
    output int         fail_count,
    output int         words_pending,
    output int         words_in,
    output int         words_out,
    output int         end_markers
);

    // How much of an escape code is currently held back.
    typedef enum logic [1:0] {
        HOLD_NONE,
        HOLD_TILDE,
        HOLD_LETTER,
        HOLD_DIGIT
    } hold_stage_t;

    // One output word as the block should deliver it.
    typedef struct packed {
        logic [7:0] ch;
        logic       valid;
        logic       last;
    } out_word_t;

    hold_stage_t hold_stage;
    logic [7:0]  held_letter;
    logic [7:0]  held_digit;
    logic [7:0]  step_bytes[$];
    out_word_t   expected_words[$];
    int          fails;
    int          n_in;
    int          n_out;
    int          n_markers;

    // ASCII hex digits, both cases.
    function automatic bit is_hex_char(input logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
    endfunction

    // Give back the bytes of a partial code unchanged and forget the code.
    function automatic void release_held();
        if (hold_stage != HOLD_NONE)
            step_bytes.push_back(CH_TILDE);
        if (hold_stage == HOLD_LETTER || hold_stage == HOLD_DIGIT)
            step_bytes.push_back(held_letter);
        if (hold_stage == HOLD_DIGIT)
            step_bytes.push_back(held_digit);
        hold_stage = HOLD_NONE;
    endfunction

    // A byte seen with nothing held: a tilde opens a code, anything else passes.
    function automatic void take_fresh(input logic [7:0] c);
        if (c == CH_TILDE)
            hold_stage = HOLD_TILDE;
        else
            step_bytes.push_back(c);
    endfunction

    // Work out the output words caused by one input word and queue them.
    function automatic void predict_words(input logic [7:0] c, input logic lst);
        int k;
        step_bytes.delete();
        case (hold_stage)
            HOLD_NONE:
                take_fresh(c);
            HOLD_TILDE:
            begin
                if (c == CH_B || c == CH_F || c == CH_C || c == CH_X)
                begin
                    held_letter = c;
                    hold_stage  = HOLD_LETTER;
                end
                else
                begin
                    release_held();
                    take_fresh(c);
                end
            end
            HOLD_LETTER:
            begin
                if (!is_hex_char(c))
                begin
                    release_held();
                    take_fresh(c);
                end
                else if (held_letter == CH_B || held_letter == CH_F)
                    hold_stage = HOLD_NONE;
                else
                begin
                    held_digit = c;
                    hold_stage = HOLD_DIGIT;
                end
            end
            default:
            begin
                if (!is_hex_char(c))
                begin
                    release_held();
                    take_fresh(c);
                end
                else
                begin
                    // A color code turns into "$0x(hh)"; a hex code just vanishes.
                    if (held_letter == CH_C)
                    begin
                        step_bytes.push_back(CH_DOLLAR);
                        step_bytes.push_back(CH_ZERO);
                        step_bytes.push_back(CH_LOW_X);
                        step_bytes.push_back(CH_LPAREN);
                        step_bytes.push_back(held_digit);
                        step_bytes.push_back(c);
                        step_bytes.push_back(CH_RPAREN);
                    end
                    hold_stage = HOLD_NONE;
                end
            end
        endcase

        // The end of a string flushes whatever is still held.
        if (lst)
            release_held();

        for (k = 0; k < step_bytes.size(); k++)
            expected_words.push_back('{ch: step_bytes[k], valid: 1'b1,
                                       last: lst && (k == step_bytes.size() - 1)});

        // A string that ends on a dropped code still gets an empty end marker.
        if (lst && step_bytes.size() == 0)
            expected_words.push_back('{ch: 8'h00, valid: 1'b0, last: 1'b1});
    endfunction

    // Watch both channels, predict on input words and compare output words.
    always @(posedge clk or negedge rst_n)
    begin
        out_word_t want;
        if (!rst_n)
        begin
            hold_stage  = HOLD_NONE;
            held_letter = 8'h00;
            held_digit  = 8'h00;
            expected_words.delete();
            fails     = 0;
            n_in      = 0;
            n_out     = 0;
            n_markers = 0;
        end
        else
        begin
            if (byte_valid && byte_ready)
            begin
                n_in++;
                predict_words(char_in, last_in);
            end
            if (res_valid && res_ready)
            begin
                n_out++;
                if (char_valid === 1'b0)
                    n_markers++;
                if (expected_words.size() == 0)
                begin
                    $error("output word %0d arrived with nothing expected: char_out %h",
                           n_out, char_out);
                    fails++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (char_out !== want.ch)
                    begin
                        $error("char_out: expected %h, got %h", want.ch, char_out);
                        fails++;
                    end
                    if (char_valid !== want.valid)
                    begin
                        $error("char_valid: expected %b, got %b", want.valid, char_valid);
                        fails++;
                    end
                    if (last_out !== want.last)
                    begin
                        $error("last_out: expected %b, got %b", want.last, last_out);
                        fails++;
                    end
                end
            end
        end
        fail_count    <= fails;
        words_pending <= expected_words.size();
        words_in      <= n_in;
        words_out     <= n_out;
        end_markers   <= n_markers;
    end

endmodule

/* dv/escape_code_stripper_top_test.sv */
`timescale 1ns / 100ps

module escape_code_stripper_top_test;
    import ecs_pkg::*;

    localparam int TIMEOUT_CYCLES  = 200000;
    localparam int RANDOM_WORDS    = 350;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int HOLD_OFF_AFTER  = 80;
    localparam int DRAIN_CYCLES    = 20;

    // One input word waiting to be sent.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_word_t;

    // Ways the receiver paces itself.
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_EVERY_FOURTH,
        RX_MOSTLY
    } rx_mode_t;

    logic       clk;
    logic       rst_n;
    logic       byte_valid;
    logic       byte_ready;
    logic [7:0] char_in;
    logic       last_in;
    logic       res_valid;
    logic       res_ready;
    logic [7:0] char_out;
    logic       char_valid;
    logic       last_out;

    int         fail_count;
    int         words_pending;
    int         words_in;
    int         words_out;
    int         end_markers;
    int         cycle_cnt = 0;
    int         n_directed;
    text_word_t text_q[$];

    escape_code_stripper_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .char_in    (char_in),
        .last_in    (last_in),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .char_out   (char_out),
        .char_valid (char_valid),
        .last_out   (last_out)
    );

    escape_code_stripper_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (byte_valid),
        .byte_ready    (byte_ready),
        .char_in       (char_in),
        .last_in       (last_in),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .char_out      (char_out),
        .char_valid    (char_valid),
        .last_out      (last_out),
        .fail_count    (fail_count),
        .words_pending (words_pending),
        .words_in      (words_in),
        .words_out     (words_out),
        .end_markers   (end_markers)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Cycle counter and watchdog.
    always @(posedge clk)
        cycle_cnt <= cycle_cnt + 1;

    initial
    begin
        wait (cycle_cnt == TIMEOUT_CYCLES);
        $display("Timed out with %0d output words still outstanding.", words_pending);
        $display("Some tests failed");
        $finish;
    end

    function automatic void add_word(input logic [7:0] ch, input logic lst);
        text_q.push_back('{ch: ch, last: lst});
    endfunction

    // Random hex digit from 0-9, a-f and A-F.
    function automatic logic [7:0] rand_hex();
        int pick;
        pick = $urandom_range(0, 21);
        if (pick < 10)
            return 8'(CH_ZERO + pick);
        else if (pick < 16)
            return 8'(8'h61 + pick - 10);
        else
            return 8'(8'h41 + pick - 16);
    endfunction

    function automatic logic [7:0] rand_letter();
        case ($urandom_range(0, 3))
            0:       return CH_B;
            1:       return CH_F;
            2:       return CH_C;
            default: return CH_X;
        endcase
    endfunction

    // A complete code: one digit after B or F, two after X or C.
    function automatic void add_code(input logic [7:0] letter);
        add_word(CH_TILDE, 1'b0);
        add_word(letter, 1'b0);
        add_word(rand_hex(), 1'b0);
        if (letter == CH_X || letter == CH_C)
            add_word(rand_hex(), 1'b0);
    endfunction

    // The first one to three bytes of a code that is never finished.
    function automatic void add_partial(input int len);
        logic [7:0] letter;
        if (len == 3)
            letter = ($urandom_range(0, 1) != 0) ? CH_X : CH_C;
        else
            letter = rand_letter();
        add_word(CH_TILDE, 1'b0);
        if (len >= 2)
            add_word(letter, 1'b0);
        if (len == 3)
            add_word(rand_hex(), 1'b0);
    endfunction

    // One string: a mix of plain text, whole codes and broken codes.
    function automatic void add_string();
        int nseg;
        int s;
        nseg = $urandom_range(1, 6);
        for (s = 0; s < nseg; s++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                    add_word(8'($urandom_range(0, 255)), 1'b0);
                3:
                    repeat ($urandom_range(2, 5))
                        add_word(8'($urandom_range(32, 126)), 1'b0);
                4, 5, 6, 7:
                    add_code(rand_letter());
                default:
                begin
                    add_partial($urandom_range(1, 3));
                    add_word(($urandom_range(0, 1) != 0) ? CH_TILDE
                                                         : 8'($urandom_range(0, 255)), 1'b0);
                end
            endcase
        end
        // Now and then the string stops in the middle of a code.
        if ($urandom_range(0, 5) == 0)
            add_partial($urandom_range(1, 3));
        text_q[text_q.size() - 1].last = 1'b1;
    endfunction

    // Offer one word and hold it until the block takes it.
    task automatic send_word(input logic [7:0] ch, input logic lst);
        byte_valid <= 1'b1;
        char_in    <= ch;
        last_in    <= lst;
        @(posedge clk);
        while (!byte_ready)
            @(posedge clk);
    endtask

    // Receiver: changes its pacing now and then, and once holds off for a long time.
    initial
    begin
        rx_mode_t rx_mode;
        int       mode_left;
        int       phase;
        int       held;
        bit       hold_done;
        rx_mode   = RX_OPEN;
        mode_left = 0;
        phase     = 0;
        hold_done = 1'b0;
        res_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (!hold_done && words_out >= HOLD_OFF_AFTER)
            begin
                hold_done = 1'b1;
                res_ready <= 1'b0;
                for (held = 0; held < HOLD_OFF_CYCLES; held++)
                    @(posedge clk);
            end
            if (mode_left == 0)
            begin
                rx_mode   = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 120);
                phase     = 0;
            end
            mode_left--;
            case (rx_mode)
                RX_OPEN:         res_ready <= 1'b1;
                RX_COIN:         res_ready <= 1'($urandom_range(0, 1));
                RX_EVERY_FOURTH: res_ready <= (phase % 4 == 0);
                default:         res_ready <= ($urandom_range(0, 7) != 0);
            endcase
            phase++;
        end
    end

    // Sender: directed words, then random strings, fed in bursts.
    initial
    begin
        int burst_left;
        int gap;
        int k;
        rst_n      <= 1'b0;
        byte_valid <= 1'b0;
        char_in    <= 8'h00;
        last_in    <= 1'b0;

        // Extreme byte values pass straight through.
        add_word(8'h00, 1'b0);
        add_word(8'hFF, 1'b0);
        // Blink code with a lowercase digit is dropped.
        add_word(CH_TILDE, 1'b0);
        add_word(CH_B, 1'b0);
        add_word("a", 1'b0);
        // Hex code is dropped.
        add_word(CH_TILDE, 1'b0);
        add_word(CH_X, 1'b0);
        add_word("1", 1'b0);
        add_word("f", 1'b0);
        // Color code is rewritten with its digits kept.
        add_word(CH_TILDE, 1'b0);
        add_word(CH_C, 1'b0);
        add_word("7", 1'b0);
        add_word("A", 1'b0);
        // Tilde followed by a letter that opens no code.
        add_word(CH_TILDE, 1'b0);
        add_word("Q", 1'b0);
        // A tilde where a digit belongs breaks the code and opens a new one.
        add_word(CH_TILDE, 1'b0);
        add_word(CH_B, 1'b0);
        add_word(CH_TILDE, 1'b0);
        // That new code breaks on its second digit.
        add_word(CH_C, 1'b0);
        add_word("1", 1'b0);
        add_word("g", 1'b0);
        // String ends with a code still held: the held bytes are flushed.
        add_word(CH_TILDE, 1'b0);
        add_word(CH_X, 1'b0);
        add_word("9", 1'b1);
        // String ends on a dropped code: only an empty end marker comes out.
        add_word(CH_TILDE, 1'b0);
        add_word(CH_F, 1'b0);
        add_word("0", 1'b1);
        n_directed = text_q.size();

        while (text_q.size() < n_directed + RANDOM_WORDS)
            add_string();

        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        burst_left = $urandom_range(1, 40);
        for (k = 0; k < text_q.size(); k++)
        begin
            if (k == n_directed || k == n_directed + RANDOM_WORDS / 2)
            begin
                // Stop and let every outstanding word come out first.
                byte_valid <= 1'b0;
                @(posedge clk);
                while (words_pending != 0)
                    @(posedge clk);
            end
            else if (burst_left <= 0)
            begin
                gap        = $urandom_range(0, 10);
                burst_left = $urandom_range(1, 40);
                if (gap != 0)
                begin
                    byte_valid <= 1'b0;
                    repeat (gap)
                        @(posedge clk);
                end
            end
            burst_left--;
            send_word(text_q[k].ch, text_q[k].last);
        end
        byte_valid <= 1'b0;

        // Wait for the tail of the output, then give the block time for strays.
        @(posedge clk);
        while (words_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("Sent %0d input words: %0d directed, the rest random strings of text and codes.",
                 words_in, n_directed);
        $display("Checked %0d output words (%0d empty end markers) under random stalls.",
                 words_out, end_markers);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
